/* hdl/bpf_pkg.sv */
// bpf_pkg: shared types and constants for the bmp pixel-to-framebuffer blitter
// no dependencies; imported by every module of the block
`default_nettype none

package bpf_pkg;

    // fixed field widths
    localparam int DIM_W   = 13;   // image size registers and pixel counters
    localparam int ORG_W   = 13;   // signed origin registers
    localparam int CFG_W   = 13;   // widest configuration register
    localparam int IDX_W   = 3;    // configuration register index
    localparam int ADDR_W  = 19;   // framebuffer word address
    localparam int COLOR_W = 32;
    localparam int SCR_W   = 12;   // screen coordinate, screen size up to 4096
    localparam int POS_W   = 15;   // signed origin plus counter

    localparam int QDEPTH  = 2;    // front-to-back queue entries
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_DEPTH_MODE   = 3'd4
    } bpf_reg_idx_t;

    typedef enum logic [1:0] {
        DEPTH_24   = 2'd0,
        DEPTH_32   = 2'd1,
        DEPTH_NONE = 2'd2
    } bpf_depth_t;

    // image geometry seen by the front
    typedef struct packed {
        logic [DIM_W-1:0] width;    // already clamped
        logic [DIM_W-1:0] height;   // already clamped
        logic [1:0]       depth;
        logic             clear;    // a register write clears the counters
    } bpf_front_cfg_t;

    // screen placement seen by the back
    typedef struct packed {
        logic [ORG_W-1:0] origin_x;
        logic [ORG_W-1:0] origin_y;
    } bpf_origin_t;

    // one assembled pixel on its way from front to back
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [DIM_W-1:0]   col;
        logic [DIM_W-1:0]   row_flip;   // row counted from the image top
        logic               last;
    } bpf_pix_rec_t;

endpackage

`default_nettype wire

/* hdl/bpf_if.sv */
// bpf_byte_if and bpf_pix_if: valid/ready channels of the blitter
// uses bpf_pkg for field widths
`default_nettype none

interface bpf_byte_if
    import bpf_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface bpf_pix_if
    import bpf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  fb_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               on_screen;
    logic               image_done;

    modport source (output valid, output fb_address, output pixel_color,
                    output on_screen, output image_done, input ready);
    modport sink   (input valid, input fb_address, input pixel_color,
                    input on_screen, input image_done, output ready);
endinterface

`default_nettype wire

/* hdl/bpf_front.sv */
// bpf_front: byte intake, padding skip, pixel assembly and row/column counting
// uses bpf_pkg and bpf_byte_if
`default_nettype none

module bpf_front
    import bpf_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    bpf_byte_if.sink            byte_in,
    input  wire bpf_front_cfg_t cfg,
    input  wire logic           q_full,
    output logic                rec_push,
    output bpf_pix_rec_t        rec
);

    logic [1:0]         phase_reg, phase_next;
    logic [COLOR_W-1:0] accum_reg, accum_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [1:0]         pad_reg, pad_next;
    logic               finished_reg, finished_next;

    logic               active;
    logic               take;
    logic [1:0]         last_phase;
    logic [COLOR_W-1:0] color_now;
    logic               row_end;
    logic               img_end;

    assign byte_in.ready = !q_full;
    assign take          = byte_in.valid && !q_full;

    assign active = !finished_reg && (cfg.depth == DEPTH_24 || cfg.depth == DEPTH_32)
                    && cfg.width != '0 && cfg.height != '0;
    assign last_phase = (cfg.depth == DEPTH_24) ? 2'd2 : 2'd3;
    assign row_end    = (col_reg == cfg.width - 1'b1);
    assign img_end    = row_end && (row_reg == cfg.height - 1'b1);

    always_comb
    begin
        color_now = accum_reg;
        color_now[{phase_reg, 3'b000} +: 8] = byte_in.data_byte;
    end

    assign rec.color    = color_now;
    assign rec.col      = col_reg;
    assign rec.row_flip = cfg.height - 1'b1 - row_reg;
    assign rec.last     = img_end;

    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pad_next      = pad_reg;
        finished_next = finished_reg;
        rec_push      = 1'b0;
        if (cfg.clear)
        begin
            phase_next    = '0;
            accum_next    = '0;
            col_next      = '0;
            row_next      = '0;
            pad_next      = '0;
            finished_next = 1'b0;
        end
        else if (take && active)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else if (phase_reg == last_phase)
            begin
                rec_push   = 1'b1;
                phase_next = '0;
                accum_next = '0;
                if (img_end)
                begin
                    finished_next = 1'b1;
                end
                else if (row_end)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    // 24-bit rows pad 3*w bytes up to a multiple of four
                    pad_next = (cfg.depth == DEPTH_24) ? cfg.width[1:0] : 2'd0;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
                accum_next = color_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            accum_reg    <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            pad_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pad_reg      <= pad_next;
            finished_reg <= finished_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/bpf_queue.sv */
// bpf_queue: short fifo of pixel records between front and back
// uses bpf_pkg
`default_nettype none

module bpf_queue
    import bpf_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bpf_pix_rec_t  push_rec,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output bpf_pix_rec_t       head
);

    bpf_pix_rec_t      mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/bpf_back.sv */
// bpf_back: screen placement, clipping and address multiply, two register stages
// uses bpf_pkg and bpf_pix_if
`default_nettype none

module bpf_back
    import bpf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bpf_origin_t   origin,
    input  wire logic          rec_valid,
    input  wire bpf_pix_rec_t  rec,
    output logic               rec_pop,
    bpf_pix_if.source          pix_out
);

    localparam logic signed [POS_W-1:0] SW_S = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] SH_S = POS_W'(SCREEN_HEIGHT);
    localparam logic [SCR_W:0]          SW_U = (SCR_W + 1)'(SCREEN_WIDTH);
    localparam int                      PROD_W = 2 * SCR_W + 2;

    // stage a: clipped screen position
    logic               a_valid_reg;
    logic [SCR_W-1:0]   a_x_reg, a_y_reg;
    logic               a_vis_reg;
    logic [COLOR_W-1:0] a_color_reg;
    logic               a_last_reg;

    // stage b: output register
    logic               b_valid_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic [COLOR_W-1:0] b_color_reg;
    logic               b_vis_reg;
    logic               b_last_reg;

    logic signed [POS_W-1:0] sx, sy;
    logic                    vis;
    logic                    a_ready, b_ready;
    logic [PROD_W-1:0]       prod;

    assign b_ready = !b_valid_reg || pix_out.ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign rec_pop = rec_valid && a_ready;

    assign sx  = {{(POS_W - ORG_W){origin.origin_x[ORG_W-1]}}, origin.origin_x}
                 + {{(POS_W - DIM_W){1'b0}}, rec.col};
    assign sy  = {{(POS_W - ORG_W){origin.origin_y[ORG_W-1]}}, origin.origin_y}
                 + {{(POS_W - DIM_W){1'b0}}, rec.row_flip};
    assign vis = (sx >= 0) && (sx < SW_S) && (sy >= 0) && (sy < SH_S);

    assign prod = PROD_W'(a_y_reg) * PROD_W'(SW_U) + PROD_W'(a_x_reg);

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            a_x_reg     <= sx[SCR_W-1:0];
            a_y_reg     <= sy[SCR_W-1:0];
            a_vis_reg   <= vis;
            a_color_reg <= rec.color;
            a_last_reg  <= rec.last;
        end
        if (a_valid_reg && b_ready)
        begin
            b_addr_reg  <= a_vis_reg ? prod[ADDR_W-1:0] : '0;
            b_color_reg <= a_color_reg;
            b_vis_reg   <= a_vis_reg;
            b_last_reg  <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= rec_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    assign pix_out.valid       = b_valid_reg;
    assign pix_out.fb_address  = b_addr_reg;
    assign pix_out.pixel_color = b_color_reg;
    assign pix_out.on_screen   = b_vis_reg;
    assign pix_out.image_done  = b_last_reg;

endmodule

`default_nettype wire

/* hdl/bmp_pixels_to_framebuffer.sv */
// bmp_pixels_to_framebuffer: top level, configuration registers and block wiring
// uses bpf_pkg, bpf_if, bpf_front, bpf_queue and bpf_back
//
// Takes the pixel array of a BMP image (after its header) one byte per
// transaction on byte_in and gives one transaction on pix_out for every
// finished pixel: framebuffer word address (screen row * SCREEN_WIDTH +
// column, 0 when clipped), colour word, on_screen and image_done on the last
// pixel. depth_mode 0 assembles three bytes blue|green|red and skips row
// padding to four bytes, 1 takes four little-endian bytes, anything else
// swallows the bytes. Rows come bottom-up and are flipped onto the screen.
// Rate: one byte per clock sustained; byte_in stalls only when the two-entry
// pixel queue is full because pix_out holds off. A pixel passes through the
// queue, the placement stage and the address multiply stage on its way to
// pix_out. A write to any listed register on the configuration port clears
// the pixel counters, so write while no transaction is in flight; bytes after
// the last pixel are dropped until the next such write.
`default_nettype none

module bmp_pixels_to_framebuffer
    import bpf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAX_IMAGE_DIM = 4096
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    bpf_byte_if.sink              byte_in,
    bpf_pix_if.source             pix_out,
    input  wire logic             cfg_write_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_write_data
);

    // largest dimension a 13-bit register can hold, capped by the parameter
    localparam int               DimCap  = (MAX_IMAGE_DIM < 8191) ? MAX_IMAGE_DIM : 8191;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DimCap);

    logic [ORG_W-1:0] origin_x_reg;
    logic [ORG_W-1:0] origin_y_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [1:0]       depth_reg;
    logic             known_idx;

    bpf_front_cfg_t   front_cfg;
    bpf_origin_t      origin;
    bpf_pix_rec_t     push_rec, head_rec;
    logic             rec_push, q_full, q_not_empty, rec_pop;

    // only a write to a listed register clears the counters
    always_comb
    begin
        unique case (cfg_index)
            REG_ORIGIN_X, REG_ORIGIN_Y, REG_IMAGE_WIDTH,
            REG_IMAGE_HEIGHT, REG_DEPTH_MODE: known_idx = 1'b1;
            default:                          known_idx = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            depth_reg    <= DEPTH_24;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg <= cfg_write_data[ORG_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg <= cfg_write_data[ORG_W-1:0];
                REG_IMAGE_WIDTH:  width_reg    <= cfg_write_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg   <= cfg_write_data[DIM_W-1:0];
                REG_DEPTH_MODE:   depth_reg    <= cfg_write_data[1:0];
                default:          ;
            endcase
        end
    end

    // oversize dimensions saturate
    assign front_cfg.width  = (width_reg > DIM_CAP) ? DIM_CAP : width_reg;
    assign front_cfg.height = (height_reg > DIM_CAP) ? DIM_CAP : height_reg;
    assign front_cfg.depth  = depth_reg;
    assign front_cfg.clear  = cfg_write_en && known_idx;

    assign origin.origin_x = origin_x_reg;
    assign origin.origin_y = origin_y_reg;

    bpf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .cfg      (front_cfg),
        .q_full   (q_full),
        .rec_push (rec_push),
        .rec      (push_rec)
    );

    bpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (rec_pop),
        .not_empty (q_not_empty),
        .head      (head_rec)
    );

    bpf_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .origin    (origin),
        .rec_valid (q_not_empty),
        .rec       (head_rec),
        .rec_pop   (rec_pop),
        .pix_out   (pix_out)
    );

endmodule

`default_nettype wire

/* hdl/bpf_checker.sv */
// bpf_checker: port-level assertions for the blitter, with its bind statement
// uses bpf_pkg; attaches to bmp_pixels_to_framebuffer
`default_nettype none

module bpf_checker
    import bpf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [ADDR_W-1:0] fb_address,
    input wire logic              on_screen,
    input wire logic              image_done,
    input wire logic              cfg_write_en
);

    localparam int FbWords = SCREEN_WIDTH * SCREEN_HEIGHT;

    logic done_seen_reg;

    // set once the final pixel has gone out, until the next register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            done_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && image_done)
        begin
            done_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel transaction dropped while stalled");

    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !on_screen |-> fb_address == '0)
        else $error("clipped pixel with nonzero address");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && on_screen |-> 32'(fb_address) < 32'(FbWords))
        else $error("on-screen pixel outside the framebuffer");

    a_none_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> !done_seen_reg)
        else $error("pixel transaction after the final pixel");

endmodule

bind bmp_pixels_to_framebuffer bpf_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_bpf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (pix_out.valid),
    .out_ready    (pix_out.ready),
    .fb_address   (pix_out.fb_address),
    .on_screen    (pix_out.on_screen),
    .image_done   (pix_out.image_done),
    .cfg_write_en (cfg_write_en)
);

`default_nettype wire

/* tb/bpf_blit_checker.sv */
// bpf_blit_checker: watches the byte and pixel channels of the blitter
// and the configuration port, and compares every pixel against its own prediction
// uses bpf_pkg and the bpf_byte_if / bpf_pix_if interfaces
`default_nettype none

module bpf_blit_checker
    import bpf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    bpf_byte_if                   byte_mon,
    bpf_pix_if                    pix_mon,
    input  wire logic             cfg_write_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_write_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int SCREEN_W = 800;
    localparam int SCREEN_H = 480;
    localparam int MAX_DIM  = 4096;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               vis;
        logic               last;
    } fb_write_t;

    fb_write_t pending_writes[$];

    // register copies
    logic signed [ORG_W-1:0] org_x;
    logic signed [ORG_W-1:0] org_y;
    logic [DIM_W-1:0]        img_w;
    logic [DIM_W-1:0]        img_h;
    logic [1:0]              depth;

    // walk through the pixel array
    int                 bytes_taken;
    logic [COLOR_W-1:0] color_acc;
    int                 col;
    int                 row;
    int                 pad_left;
    bit                 done;

    initial mismatches = 0;

    function void restart_image();
        bytes_taken = 0;
        color_acc   = '0;
        col         = 0;
        row         = 0;
        pad_left    = 0;
        done        = 1'b0;
    endfunction

    task report_mismatch(input string msg);
        $display("bpf_blit_checker: %s", msg);
        mismatches++;
    endtask

    // one byte of the pixel array; pushes a framebuffer write when a pixel completes
    function void blit_byte(input logic [7:0] b);
        int        w;
        int        h;
        int        sx;
        int        sy;
        fb_write_t px;
        w = (img_w > MAX_DIM) ? MAX_DIM : int'(img_w);
        h = (img_h > MAX_DIM) ? MAX_DIM : int'(img_h);
        if (done || (depth != DEPTH_24 && depth != DEPTH_32) || w == 0 || h == 0)
            return;
        if (pad_left != 0)
        begin
            pad_left--;
            return;
        end
        color_acc = color_acc | (COLOR_W'(b) << (8 * bytes_taken));
        bytes_taken++;
        if (bytes_taken < ((depth == DEPTH_24) ? 3 : 4))
            return;
        // rows come bottom-up
        sx = int'(org_x) + col;
        sy = int'(org_y) + (h - 1 - row);
        px.vis   = (sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H);
        px.addr  = px.vis ? ADDR_W'(sy * SCREEN_W + sx) : '0;
        px.color = color_acc;
        px.last  = (row == h - 1) && (col == w - 1);
        pending_writes.push_back(px);
        bytes_taken = 0;
        color_acc   = '0;
        if (px.last)
            done = 1'b1;
        else if (col + 1 >= w)
        begin
            col      = 0;
            row++;
            pad_left = (depth == DEPTH_24) ? (w & 3) : 0;
        end
        else
            col++;
    endfunction

    always @(posedge clk)
    begin : watch
        fb_write_t want;
        if (!rst_n)
        begin
            org_x = '0;
            org_y = '0;
            img_w = WIDTH_RESET;
            img_h = HEIGHT_RESET;
            depth = DEPTH_24;
            restart_image();
            pending_writes.delete();
        end
        else
        begin
            // compare before predicting, so a stray pixel never meets a fresh expectation
            if (pix_mon.valid && pix_mon.ready)
            begin
                if (pending_writes.size() == 0)
                    report_mismatch($sformatf("unexpected pixel at address %0d",
                                              pix_mon.fb_address));
                else
                begin
                    want = pending_writes.pop_front();
                    if (pix_mon.fb_address !== want.addr)
                        report_mismatch($sformatf("fb_address expected %0d got %0d",
                                                  want.addr, pix_mon.fb_address));
                    if (pix_mon.pixel_color !== want.color)
                        report_mismatch($sformatf("pixel_color expected %h got %h",
                                                  want.color, pix_mon.pixel_color));
                    if (pix_mon.on_screen !== want.vis)
                        report_mismatch($sformatf("on_screen expected %b got %b",
                                                  want.vis, pix_mon.on_screen));
                    if (pix_mon.image_done !== want.last)
                        report_mismatch($sformatf("image_done expected %b got %b",
                                                  want.last, pix_mon.image_done));
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:     org_x = cfg_write_data[ORG_W-1:0];
                    REG_ORIGIN_Y:     org_y = cfg_write_data[ORG_W-1:0];
                    REG_IMAGE_WIDTH:  img_w = cfg_write_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: img_h = cfg_write_data[DIM_W-1:0];
                    REG_DEPTH_MODE:   depth = cfg_write_data[1:0];
                    default: ;
                endcase
                // unused indexes leave the counters alone
                if (cfg_index <= REG_DEPTH_MODE)
                    restart_image();
            end
            if (byte_mon.valid && byte_mon.ready)
                blit_byte(byte_mon.data_byte);
        end
        outstanding <= pending_writes.size();
    end

endmodule

`default_nettype wire

/* tb/bmp_pixels_to_framebuffer_test.sv */
// bmp_pixels_to_framebuffer_test: top of the blitter testbench; drives byte and
// configuration traffic, throttles the pixel side and gives the verdict
// uses bpf_pkg, bpf_if, the blitter RTL and bpf_blit_checker
`default_nettype none

module bmp_pixels_to_framebuffer_test;
    import bpf_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int ITEM_TARGET   = 650;      // counted bytes in the random part
    localparam int SETTLE_CYCLES = 8;        // pipeline is three stages deep
    localparam int HOLD_CYCLES   = 80;       // long pixel-side hold-off
    localparam int CYCLE_LIMIT   = 400000;

    // index past the register list, and the second unsupported depth code
    localparam logic [IDX_W-1:0] REG_SPARE   = 3'd5;
    localparam logic [1:0]       DEPTH_SPARE = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_write_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_write_data;

    int mismatches;
    int outstanding;
    int bytes_sent;
    int cycle_count;
    bit no_gaps;         // stretch with both sides running flat out
    bit hold_request;    // asks the pixel side for one long hold-off

    bpf_byte_if byte_bus ();
    bpf_pix_if  pix_bus ();

    bmp_pixels_to_framebuffer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_in        (byte_bus),
        .pix_out        (pix_bus),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data)
    );

    bpf_blit_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_mon       (byte_bus),
        .pix_mon        (pix_bus),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one byte transaction, with a random idle stretch in front of it
    task send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= b;
        do
            @(posedge clk);
        while (byte_bus.ready !== 1'b1);
    endtask

    // random bytes; ignored ones are kept out of the item count
    task stream_random(input int n, input bit counted);
        repeat (n)
        begin
            send_byte(8'($urandom));
            if (counted)
                bytes_sent++;
        end
    endtask

    // stop offering bytes, wait for every predicted pixel, then let the pipe empty
    task wait_drained();
        byte_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write_en   <= 1'b1;
        cfg_index      <= idx;
        cfg_write_data <= data;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        @(posedge clk);
    endtask

    task configure(input int ox, input int oy, input int w, input int h,
                   input logic [1:0] d);
        logic [CFG_W-1:0] depth_word;
        depth_word      = CFG_W'($urandom);    // upper bits are don't-care
        depth_word[1:0] = d;
        write_reg(REG_ORIGIN_X, CFG_W'(ox));
        write_reg(REG_ORIGIN_Y, CFG_W'(oy));
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        write_reg(REG_DEPTH_MODE, depth_word);
    endtask

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bmp_pixels_to_framebuffer_test NOT OK");
        $finish;
    end

    // pixel side: random ready pattern, plus a long hold-off on request
    initial
    begin
        int gap;
        pix_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                // counted here while the byte side keeps pushing, so the queue
                // fills and byte_in has to stall
                hold_request = 1'b0;
                pix_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap != 0)
                begin
                    pix_bus.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                pix_bus.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int         w;
        int         h;
        int         ox;
        int         oy;
        int         bpp;
        int         len;
        int         cut;
        int         kind;
        int         big;
        bit         first;
        logic [1:0] d;

        rst_n              <= 1'b0;
        byte_bus.valid     <= 1'b0;
        byte_bus.data_byte <= '0;
        cfg_write_en       <= 1'b0;
        cfg_index          <= '0;
        cfg_write_data     <= '0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----

        // reset geometry 800x480 24-bit: first pixel lands on the bottom screen row
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h5a);
        wait_drained();

        // one pixel wide, two rows: a padding byte per row and bytes after the image
        configure(0, 0, 1, 2, DEPTH_24);
        stream_random(9, 1'b0);
        wait_drained();

        // extreme origin, width past the saturation point and height at it: clipped pixel
        configure(-4096, 4095, 8191, 4096, DEPTH_32);
        stream_random(4, 1'b0);
        wait_drained();

        // bottom-right screen corner, then one column past the right edge
        configure(799, 479, 2, 1, DEPTH_32);
        stream_random(8, 1'b0);
        wait_drained();

        // nothing drawn: zero width, zero height, both unsupported depths
        configure(0, 0, 0, 3, DEPTH_24);
        stream_random(3, 1'b0);
        wait_drained();
        configure(0, 0, 2, 0, DEPTH_32);
        stream_random(3, 1'b0);
        wait_drained();
        configure(0, 0, 2, 2, DEPTH_NONE);
        stream_random(4, 1'b0);
        wait_drained();
        configure(0, 0, 2, 2, DEPTH_SPARE);
        stream_random(4, 1'b0);
        wait_drained();

        // ---- random part ----
        first = 1'b1;
        while (bytes_sent < ITEM_TARGET)
        begin
            kind    = first ? 0 : $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 5) == 0);
            if (kind < 75)
            begin
                // well-formed image with random placement and pixels
                w = first ? 7 : $urandom_range(1, 7);
                h = first ? 4 : $urandom_range(1, 4);
                d = ($urandom_range(0, 1) == 1) ? DEPTH_32 : DEPTH_24;
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        ox = $urandom_range(0, 800 - w);
                        oy = $urandom_range(0, 480 - h);
                    end
                    2:
                    begin
                        // straddling the screen edges
                        ox = ($urandom_range(0, 1) == 1) ? 795 + int'($urandom_range(0, 8))
                                                         : -int'($urandom_range(0, 8));
                        oy = ($urandom_range(0, 1) == 1) ? 476 + int'($urandom_range(0, 6))
                                                         : -int'($urandom_range(0, 5));
                    end
                    default:
                    begin
                        ox = int'($urandom_range(0, 8191)) - 4096;
                        oy = int'($urandom_range(0, 8191)) - 4096;
                    end
                endcase
                configure(ox, oy, w, h, d);
                bpp = (d == DEPTH_24) ? 3 : 4;
                len = h * (w * bpp + ((d == DEPTH_24) ? (w & 3) : 0));
                // the first image rides through a long pixel-side hold-off
                if (first || $urandom_range(0, 19) == 0)
                    hold_request = 1'b1;
                if (!first && len > 1 && $urandom_range(0, 6) == 0)
                    stream_random($urandom_range(1, len - 1), 1'b1);  // broken off early
                else if (!first && len > 1 && $urandom_range(0, 6) == 0)
                begin
                    // a write past the register list must not disturb the image
                    cut = len / 2;
                    stream_random(cut, 1'b1);
                    wait_drained();
                    write_reg(REG_SPARE, CFG_W'($urandom));
                    stream_random(len - cut, 1'b1);
                end
                else
                begin
                    stream_random(len, 1'b1);
                    stream_random($urandom_range(0, 4), 1'b0);  // after the image
                end
            end
            else if (kind < 87)
            begin
                // a dimension near, at or beyond the limit; only the start of the image
                case ($urandom_range(0, 3))
                    0: big = 4095;
                    1: big = 4096;
                    2: big = 4097;
                    default: big = 8191;
                endcase
                d = ($urandom_range(0, 1) == 1) ? DEPTH_32 : DEPTH_24;
                if ($urandom_range(0, 1) == 1)
                    configure(-int'($urandom_range(0, 3)), $urandom_range(0, 479),
                              big, $urandom_range(1, 3), d);
                else
                    // pull the flipped bottom rows up onto the screen
                    configure($urandom_range(0, 799), -int'($urandom_range(3616, 4096)),
                              $urandom_range(1, 3), big, d);
                stream_random($urandom_range(8, 20), 1'b1);
            end
            else
            begin
                // images that draw nothing
                case ($urandom_range(0, 3))
                    0: configure(0, 0, 0, $urandom_range(1, 4), DEPTH_24);
                    1: configure(0, 0, $urandom_range(1, 4), 0, DEPTH_32);
                    2: configure(0, 0, $urandom_range(1, 4), $urandom_range(1, 4), DEPTH_NONE);
                    default: configure(0, 0, $urandom_range(1, 4), $urandom_range(1, 4),
                                       DEPTH_SPARE);
                endcase
                stream_random($urandom_range(3, 8), 1'b0);
            end
            wait_drained();
            first = 1'b0;
        end

        no_gaps = 1'b0;
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("bmp_pixels_to_framebuffer_test OK");
        else
            $display("bmp_pixels_to_framebuffer_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
